FILE: rtl/lossy_pixel_rle_encoder_assert.svh
// Assertion macros shared by the run-length encoder RTL.
// No dependencies; included by the modules that carry checks.
`ifndef LOSSY_PIXEL_RLE_ENCODER_ASSERT_SVH
`define LOSSY_PIXEL_RLE_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define LPRE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define LPRE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/lpre_pkg.sv
// Package for the lossy pixel run-length encoder: types, constants, mask table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lpre_pkg;

    // Register map (index = paddr[3:2])
    localparam int          PADDR_W      = 4;
    localparam logic [1:0]  REG_QUALITY  = 2'd0;
    localparam logic [1:0]  REG_LOSSLESS = 2'd1;
    localparam logic [1:0]  REG_HAS_ALPHA = 2'd2;

    localparam logic [2:0]  QUALITY_RESET = 3'd3;

    // Extra-repeat limits per mode
    localparam logic [7:0]  RGBA_RUN_LIMIT = 8'h7F;
    localparam logic [7:0]  RGB_RUN_LIMIT  = 8'd255;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [2:0] quality_level;
        logic       lossless_mode;
        logic       has_alpha;
    } cfg_t;

    // One run word as it leaves the block
    typedef struct packed {
        logic [7:0] run_red;
        logic [7:0] run_green;
        logic [7:0] run_blue;
        logic [7:0] run_byte;
        logic       final_word;
    } word_t;

    // Work for one pixel: an optional closing word, then an optional final word
    typedef struct packed {
        logic  close_valid;
        word_t close_word;
        logic  flush_valid;
        word_t flush_word;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } mask_t;

    // Per-level color masks; out-of-range levels behave as level 1
    function automatic mask_t level_mask(input logic [2:0] lvl);
        mask_t m;
        unique case (lvl)
            3'd0:    m = '{red: 8'hFF, green: 8'hFF, blue: 8'hFF};
            3'd1:    m = '{red: 8'hFE, green: 8'hFF, blue: 8'hFE};
            3'd2:    m = '{red: 8'hFC, green: 8'hFE, blue: 8'hFC};
            3'd3:    m = '{red: 8'hF8, green: 8'hFC, blue: 8'hF8};
            3'd4:    m = '{red: 8'hF0, green: 8'hF8, blue: 8'hF0};
            3'd5:    m = '{red: 8'hE0, green: 8'hF0, blue: 8'hE0};
            default: m = '{red: 8'hFE, green: 8'hFF, blue: 8'hFE};
        endcase
        return m;
    endfunction

    // Count byte: alpha flag in bit 7 for RGBA, full count for RGB
    function automatic logic [7:0] count_byte(input logic has_alpha,
                                              input logic [7:0] count,
                                              input logic [7:0] alpha);
        return has_alpha ? {(alpha != 8'd0), count[6:0]} : count;
    endfunction

endpackage

FILE: rtl/lossy_pixel_rle_encoder.sv
// Lossy pixel run-length encoder: top level with the APB register block.
// Depends on lpre_pkg, lpre_front, lpre_queue and lpre_back.
`timescale 1ns / 1ps

// Usage:
// One pixel (s_red/s_green/s_blue/s_alpha, s_last_pixel) per s_ beat.
// Each closed run leaves as one m_ beat: the run's first pixel color, a
// count byte of extra repeats (bit 7 = alpha nonzero in RGBA mode) and
// m_final_word on the word that ends the image.
// Throughput: one pixel per clock while the queue is not full; a pixel that
// both closes a run and ends the image yields two words.
// A word caused by a pixel is written into the queue and then loaded into
// the output register, where it is valid and can leave given a free output;
// the second word of a pair waits behind it in a pending register.
// The output register sets the rate: one word per cycle with m_ready high.
// When m_ready is low, words collect in a four-entry queue; s_ready falls
// once it is full and rises again as the receiver drains it.
// Registers (APB, byte address 4*i): quality_level, lossless_mode,
// has_alpha. Write them only while the block is idle.
// Reset (aresetn low, synchronous) empties the queue, drops any open run and
// loads quality_level=3, lossless_mode=0, has_alpha=1.
module lossy_pixel_rle_encoder
    import lpre_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // APB register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // Pixel channel
    input  logic [7:0]         s_red,
    input  logic [7:0]         s_green,
    input  logic [7:0]         s_blue,
    input  logic [7:0]         s_alpha,
    input  logic               s_last_pixel,
    input  logic               s_valid,
    output logic               s_ready,
    // Run word channel
    output logic [7:0]         m_run_red,
    output logic [7:0]         m_run_green,
    output logic [7:0]         m_run_blue,
    output logic [7:0]         m_run_byte,
    output logic               m_final_word,
    output logic               m_valid,
    input  logic               m_ready
);

    cfg_t    cfg_reg;
    logic    cfg_wr;
    logic    push;
    logic    pop;
    entry_t  push_entry;
    entry_t  head;
    q_stat_t q_stat;
    word_t   m_word;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.quality_level <= QUALITY_RESET;
            cfg_reg.lossless_mode <= 1'b0;
            cfg_reg.has_alpha     <= 1'b1;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_QUALITY:   cfg_reg.quality_level <= pwdata[2:0];
                REG_LOSSLESS:  cfg_reg.lossless_mode <= pwdata[0];
                REG_HAS_ALPHA: cfg_reg.has_alpha     <= pwdata[0];
                default:       ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (paddr[3:2])
            REG_QUALITY:   prdata = {29'd0, cfg_reg.quality_level};
            REG_LOSSLESS:  prdata = {31'd0, cfg_reg.lossless_mode};
            REG_HAS_ALPHA: prdata = {31'd0, cfg_reg.has_alpha};
            default:       prdata = 32'd0;
        endcase
    end

    lpre_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .s_red        (s_red),
        .s_green      (s_green),
        .s_blue       (s_blue),
        .s_alpha      (s_alpha),
        .s_last_pixel (s_last_pixel),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .q_stat       (q_stat),
        .push         (push),
        .push_entry   (push_entry)
    );

    lpre_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_stat     (q_stat)
    );

    lpre_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .q_stat  (q_stat),
        .pop     (pop),
        .m_word  (m_word),
        .m_valid (m_valid),
        .m_ready (m_ready)
    );

    assign m_run_red    = m_word.run_red;
    assign m_run_green  = m_word.run_green;
    assign m_run_blue   = m_word.run_blue;
    assign m_run_byte   = m_word.run_byte;
    assign m_final_word = m_word.final_word;

endmodule

FILE: rtl/lpre_front.sv
// Front end: accepts pixels, tracks the open run and queues the words to emit.
// Depends on lpre_pkg and lossy_pixel_rle_encoder_assert.svh.
`timescale 1ns / 1ps
`include "lossy_pixel_rle_encoder_assert.svh"

module lpre_front
    import lpre_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic [7:0] s_red,
    input  logic [7:0] s_green,
    input  logic [7:0] s_blue,
    input  logic [7:0] s_alpha,
    input  logic       s_last_pixel,
    input  logic       s_valid,
    output logic       s_ready,
    input  q_stat_t    q_stat,
    output logic       push,
    output entry_t     push_entry
);

    logic [7:0] run_red_reg, run_green_reg, run_blue_reg, run_alpha_reg;
    logic [7:0] run_red_next, run_green_next, run_blue_next, run_alpha_next;
    logic [7:0] run_count_reg, run_count_next;
    logic       run_open_reg, run_open_next;

    logic       accept;
    logic       join_run;
    logic       color_match;
    logic       below_limit;
    mask_t      mask;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;

    // Masked compare against the run's first pixel
    always_comb begin
        mask = level_mask(cfg.lossless_mode ? 3'd0 : cfg.quality_level);
        color_match = ((run_red_reg   & mask.red)   == (s_red   & mask.red))
                   && ((run_green_reg & mask.green) == (s_green & mask.green))
                   && ((run_blue_reg  & mask.blue)  == (s_blue  & mask.blue))
                   && (!cfg.has_alpha || (run_alpha_reg == s_alpha));
        below_limit = run_count_reg < (cfg.has_alpha ? RGBA_RUN_LIMIT : RGB_RUN_LIMIT);
        join_run    = run_open_reg && below_limit && color_match;
    end

    // Next run state
    always_comb begin
        run_red_next   = join_run ? run_red_reg   : s_red;
        run_green_next = join_run ? run_green_reg : s_green;
        run_blue_next  = join_run ? run_blue_reg  : s_blue;
        run_alpha_next = join_run ? run_alpha_reg : s_alpha;
        run_count_next = join_run ? run_count_reg + 8'd1 : 8'd0;
        run_open_next  = !s_last_pixel;
    end

    // Words caused by this pixel
    always_comb begin
        push_entry.close_valid           = run_open_reg && !join_run;
        push_entry.close_word.run_red    = run_red_reg;
        push_entry.close_word.run_green  = run_green_reg;
        push_entry.close_word.run_blue   = run_blue_reg;
        push_entry.close_word.run_byte   = count_byte(cfg.has_alpha, run_count_reg,
                                                      run_alpha_reg);
        push_entry.close_word.final_word = 1'b0;
        push_entry.flush_valid           = s_last_pixel;
        push_entry.flush_word.run_red    = run_red_next;
        push_entry.flush_word.run_green  = run_green_next;
        push_entry.flush_word.run_blue   = run_blue_next;
        push_entry.flush_word.run_byte   = count_byte(cfg.has_alpha, run_count_next,
                                                      run_alpha_next);
        push_entry.flush_word.final_word = 1'b1;
        push = accept && (push_entry.close_valid || push_entry.flush_valid);
    end

    // Run color registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            run_red_reg   <= run_red_next;
            run_green_reg <= run_green_next;
            run_blue_reg  <= run_blue_next;
            run_alpha_reg <= run_alpha_next;
        end
    end

    // Run control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_count_reg <= 8'd0;
            run_open_reg  <= 1'b0;
        end else if (accept) begin
            run_count_reg <= s_last_pixel ? 8'd0 : run_count_next;
            run_open_reg  <= run_open_next;
        end
    end

    `LPRE_ASSERT_NEXT(a_last_closes_run, aclk, aresetn, accept && s_last_pixel,
        !run_open_reg && (run_count_reg == 8'd0), "run left open after last pixel")
    `LPRE_ASSERT_NOW(a_idle_count_zero, aclk, aresetn, !run_open_reg,
        run_count_reg == 8'd0, "repeat count nonzero with no open run")

endmodule

FILE: rtl/lpre_queue.sv
// Short queue of per-pixel word entries between front and back.
// Depends on lpre_pkg and lossy_pixel_rle_encoder_assert.svh.
`timescale 1ns / 1ps
`include "lossy_pixel_rle_encoder_assert.svh"

module lpre_queue
    import lpre_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  entry_t  push_entry,
    input  logic    pop,
    output entry_t  head,
    output q_stat_t q_stat
);

    entry_t             q_mem_reg [QUEUE_DEPTH];
    logic [QIDX_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QIDX_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign head         = q_mem_reg[rd_ptr_reg];
    assign q_stat.full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign q_stat.empty = count_reg == '0;

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QIDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QIDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `LPRE_ASSERT_NOW(a_no_overflow, aclk, aresetn, push, !q_stat.full || pop,
        "push into full queue")
    `LPRE_ASSERT_NOW(a_no_underflow, aclk, aresetn, pop, !q_stat.empty,
        "pop from empty queue")
    `LPRE_ASSERT_NOW(a_entry_has_word, aclk, aresetn, push,
        push_entry.close_valid || push_entry.flush_valid, "queued entry carries no word")

endmodule

FILE: rtl/lpre_back.sv
// Back end: expands queued entries into run words and holds the output register.
// Depends on lpre_pkg and lossy_pixel_rle_encoder_assert.svh.
`timescale 1ns / 1ps
`include "lossy_pixel_rle_encoder_assert.svh"

module lpre_back
    import lpre_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  entry_t  head,
    input  q_stat_t q_stat,
    output logic    pop,
    output word_t   m_word,
    output logic    m_valid,
    input  logic    m_ready
);

    word_t cur_reg, cur_next;
    word_t pend_reg, pend_next;
    logic  m_valid_reg, m_valid_next;
    logic  pend_valid_reg, pend_valid_next;
    logic  out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_word   = cur_reg;
    assign m_valid  = m_valid_reg;

    // Load the output register from the pending word or the queue head
    always_comb begin
        cur_next        = cur_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg;
        pend_valid_next = pend_valid_reg;
        pop             = 1'b0;
        if (out_free) begin
            if (pend_valid_reg) begin
                cur_next        = pend_reg;
                m_valid_next    = 1'b1;
                pend_valid_next = 1'b0;
            end else if (!q_stat.empty) begin
                pop          = 1'b1;
                m_valid_next = 1'b1;
                pend_next    = head.flush_word;
                if (head.close_valid) begin
                    cur_next        = head.close_word;
                    pend_valid_next = head.flush_valid;
                end else begin
                    cur_next        = head.flush_word;
                    pend_valid_next = 1'b0;
                end
            end else begin
                m_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg  <= cur_next;
        pend_reg <= pend_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    `LPRE_ASSERT_NOW(a_pend_behind_cur, aclk, aresetn, pend_valid_reg, m_valid_reg,
        "pending word without a current word")

endmodule
